// ===== rtl/core/f32f16_pkg.sv =====
// Package: shared types, codes and constants for the float32/float16 converter.
package f32f16_pkg;

	// Direction codes carried by the command field
	typedef enum logic {
		CMD_S2H = 1'b0,
		CMD_H2S = 1'b1
	} cmd_t;

	// Operand class decided at decode
	typedef enum logic [2:0] {
		KIND_ZERO,
		KIND_NORM,
		KIND_SUB,
		KIND_INF,
		KIND_NAN
	} kind_t;

	// Pipeline payload between stages
	typedef struct packed {
		cmd_t        cmd;
		logic        sign;
		kind_t       kind;
		logic [3:0]  shamt;
		logic [7:0]  ex;
		logic [9:0]  frac;
	} pipe_t;

	// Single-precision field limits
	localparam logic [7:0] S_EX_MAX     = 8'hFF;
	localparam logic [7:0] S_EX_OVF     = 8'd143;
	localparam logic [7:0] S_EX_SUB     = 8'd112;
	localparam logic [7:0] S_EX_SUBBIAS = 8'd113;
	localparam logic [7:0] S_EX_SATSH   = 8'd102;
	localparam logic [3:0] SH_MAX       = 4'd11;

	// Half-precision field limits and rebias values
	localparam logic [4:0] H_EX_MAX     = 5'h1F;
	localparam logic [7:0] H_TO_S_BIAS  = 8'd112;
	localparam logic [7:0] H_SUB_BIAS   = 8'd103;
	localparam logic [3:0] H_MSB_POS    = 4'd10;

	// Special result patterns
	localparam logic [15:0] H_NAN_POS  = 16'h7FFF;
	localparam logic [15:0] H_NAN_NEG  = 16'hFFFF;
	localparam logic [15:0] H_INF_POS  = 16'h7C00;
	localparam logic [15:0] H_INF_NEG  = 16'hFC00;
	localparam logic [31:0] S_NAN_POS  = 32'h7FFFFFFF;
	localparam logic [31:0] S_NAN_NEG  = 32'hFFFFFFFF;
	localparam logic [31:0] S_INF_POS  = 32'h7F800000;
	localparam logic [31:0] S_INF_NEG  = 32'hFF800000;

	// Position of the highest set bit of a 10-bit mantissa (0 when none)
	function automatic logic [3:0] lead_one(input logic [9:0] f);
		logic [3:0] p;
		p = 4'd0;
		for (int i = 0; i < 10; i++) begin
			if (f[i]) begin
				p = 4'(i);
			end
		end
		return p;
	endfunction

endpackage

// ===== rtl/core/f32f16_decode.sv =====
// Input decode: splits the operand into sign, exponent, mantissa and class.
module f32f16_decode (
	input  logic                command,
	input  logic [31:0]         value,
	output f32f16_pkg::pipe_t   dec
);

	logic [7:0]  s_ex;
	logic [4:0]  h_ex;
	logic [9:0]  h_frac;

	assign s_ex   = value[30:23];
	assign h_ex   = value[14:10];
	assign h_frac = value[9:0];

	// Classify per direction
	always_comb begin
		dec.cmd   = f32f16_pkg::cmd_t'(command);
		dec.shamt = 4'd0;
		if (command == f32f16_pkg::CMD_S2H) begin
			dec.sign = value[31];
			dec.ex   = s_ex;
			dec.frac = value[22:13];
			if (s_ex == f32f16_pkg::S_EX_MAX) begin
				dec.kind = (value[22:0] != 23'd0) ? f32f16_pkg::KIND_NAN
				                                  : f32f16_pkg::KIND_INF;
			end else if (s_ex == 8'd0) begin
				dec.kind = f32f16_pkg::KIND_ZERO;
			end else if (s_ex >= f32f16_pkg::S_EX_OVF) begin
				dec.kind = f32f16_pkg::KIND_INF;
			end else if (s_ex <= f32f16_pkg::S_EX_SUB) begin
				dec.kind = f32f16_pkg::KIND_SUB;
			end else begin
				dec.kind = f32f16_pkg::KIND_NORM;
			end
		end else begin
			// upper half of value is ignored
			dec.sign = value[15];
			dec.ex   = {3'd0, h_ex};
			dec.frac = h_frac;
			if (h_ex == f32f16_pkg::H_EX_MAX) begin
				dec.kind = (h_frac != 10'd0) ? f32f16_pkg::KIND_NAN
				                             : f32f16_pkg::KIND_INF;
			end else if (h_ex == 5'd0) begin
				dec.kind = (h_frac == 10'd0) ? f32f16_pkg::KIND_ZERO
				                             : f32f16_pkg::KIND_SUB;
			end else begin
				dec.kind = f32f16_pkg::KIND_NORM;
			end
		end
	end

endmodule

// ===== rtl/core/float32_float16_converter_core.sv =====
// Top level: three-stage float32 <-> float16 conversion pipeline.
// One beat is taken on every clock where start is high; busy is always low,
// so a beat may follow in the very next cycle. Each result appears on result
// with done high for one cycle, after passing through decode, exponent/shift
// setup and mantissa shift and pack (one register each), in input order.
// Half results are zero-extended to 32 bits.
module float32_float16_converter_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        command,
	input  logic [31:0] value,
	output logic        done,
	output logic [31:0] result
);

	f32f16_pkg::pipe_t dec;
	f32f16_pkg::pipe_t pipe_s1;
	f32f16_pkg::pipe_t pipe_s2;
	f32f16_pkg::pipe_t nxt_s2;
	logic              valid_s1;
	logic              valid_s2;
	logic              valid_s3;
	logic [31:0]       result_s3;
	logic [31:0]       nxt_result;
	logic [3:0]        lead;
	logic [10:0]       sub_h;
	logic [10:0]       norm_s;

	// Pipeline never stalls
	assign busy = 1'b0;

	f32f16_decode u_decode (
		.command (command),
		.value   (value),
		.dec     (dec)
	);

	// Valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		pipe_s1   <= dec;
		pipe_s2   <= nxt_s2;
		result_s3 <= nxt_result;
	end

	// Stage 2: exponent rebias and shift amount
	assign lead = f32f16_pkg::lead_one(pipe_s1.frac);

	always_comb begin
		nxt_s2 = pipe_s1;
		if (pipe_s1.cmd == f32f16_pkg::CMD_S2H) begin
			if (pipe_s1.ex <= f32f16_pkg::S_EX_SATSH) begin
				nxt_s2.shamt = f32f16_pkg::SH_MAX;
			end else begin
				nxt_s2.shamt = 4'(f32f16_pkg::S_EX_SUBBIAS - pipe_s1.ex);
			end
			nxt_s2.ex = pipe_s1.ex - f32f16_pkg::S_EX_SUB;
		end else begin
			if (pipe_s1.kind == f32f16_pkg::KIND_SUB) begin
				// normalize so the leading one lands on bit 10
				nxt_s2.shamt = f32f16_pkg::H_MSB_POS - lead;
				nxt_s2.ex    = {4'd0, lead} + f32f16_pkg::H_SUB_BIAS;
			end else begin
				nxt_s2.shamt = 4'd0;
				nxt_s2.ex    = pipe_s1.ex + f32f16_pkg::H_TO_S_BIAS;
			end
		end
	end

	// Stage 3: mantissa shift and pack
	assign sub_h  = {1'b1, pipe_s2.frac} >> pipe_s2.shamt;
	assign norm_s = {1'b0, pipe_s2.frac} << pipe_s2.shamt;

	always_comb begin
		if (pipe_s2.cmd == f32f16_pkg::CMD_S2H) begin
			case (pipe_s2.kind)
				f32f16_pkg::KIND_NAN: begin
					nxt_result = {16'd0, pipe_s2.sign ? f32f16_pkg::H_NAN_NEG
					                                  : f32f16_pkg::H_NAN_POS};
				end
				f32f16_pkg::KIND_INF: begin
					nxt_result = {16'd0, pipe_s2.sign ? f32f16_pkg::H_INF_NEG
					                                  : f32f16_pkg::H_INF_POS};
				end
				f32f16_pkg::KIND_SUB: begin
					nxt_result = {16'd0, pipe_s2.sign, 5'd0, sub_h[9:0]};
				end
				f32f16_pkg::KIND_NORM: begin
					nxt_result = {16'd0, pipe_s2.sign, pipe_s2.ex[4:0], pipe_s2.frac};
				end
				default: begin
					nxt_result = {16'd0, pipe_s2.sign, 15'd0};
				end
			endcase
		end else begin
			case (pipe_s2.kind)
				f32f16_pkg::KIND_NAN: begin
					nxt_result = pipe_s2.sign ? f32f16_pkg::S_NAN_NEG
					                          : f32f16_pkg::S_NAN_POS;
				end
				f32f16_pkg::KIND_INF: begin
					nxt_result = pipe_s2.sign ? f32f16_pkg::S_INF_NEG
					                          : f32f16_pkg::S_INF_POS;
				end
				f32f16_pkg::KIND_SUB: begin
					nxt_result = {pipe_s2.sign, pipe_s2.ex, norm_s[9:0], 13'd0};
				end
				f32f16_pkg::KIND_NORM: begin
					nxt_result = {pipe_s2.sign, pipe_s2.ex, pipe_s2.frac, 13'd0};
				end
				default: begin
					nxt_result = {pipe_s2.sign, 31'd0};
				end
			endcase
		end
	end

	assign done   = valid_s3;
	assign result = result_s3;

	// Every accepted beat yields a result with done high
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> ##3 done)
		else $error("result missing three cycles after start");

	// No result without a matching start beat
	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!start |-> ##3 !done)
		else $error("result without a matching start");

	// Half results are zero-extended
	a_half_zext: assert property (@(posedge clk) disable iff (!arst_n)
		(start && command == f32f16_pkg::CMD_S2H) |-> ##3 (result[31:16] == 16'd0))
		else $error("half result not zero-extended");

	// Denormal right shift stays within 1..11
	a_sub_shift: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s2 && pipe_s2.cmd == f32f16_pkg::CMD_S2H
		 && pipe_s2.kind == f32f16_pkg::KIND_SUB)
		|-> (pipe_s2.shamt >= 4'd1 && pipe_s2.shamt <= f32f16_pkg::SH_MAX))
		else $error("denormal shift out of range");

endmodule
